// ----- design/bracketed_integer_list_parser_macros.svh -----
// ----------------------------------------------------------------------------
// Bracketed integer list parser: assertion macros
// Concurrent check wrappers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BRACKETED_INTEGER_LIST_PARSER_MACROS_SVH
`define BRACKETED_INTEGER_LIST_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
`define BILP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BILP_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BILP_ASSERT(lbl, clk, rst, prop, msg)
`define BILP_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ----- design/bilp_pkg.sv -----
// ----------------------------------------------------------------------------
// bilp_pkg
// Shared types and constants of the bracketed integer list parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bilp_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int OUT_BITS           = 32;
   localparam int COUNT_BITS         = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [7:0] CH_OPEN  = 8'h5B;   // '['
   localparam logic [7:0] CH_CLOSE = 8'h5D;   // ']'
   localparam logic [7:0] CH_COMMA = 8'h2C;   // ','
   localparam logic [7:0] CH_SPACE = 8'h20;   // ' '
   localparam logic [7:0] CH_PLUS  = 8'h2B;   // '+'
   localparam logic [7:0] CH_MINUS = 8'h2D;   // '-'
   localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;   // '9'
   localparam logic [7:0] CH_TAB   = 8'h09;   // first of tab, LF, VT, FF, CR
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_OPEN  = 2'd1;
   localparam logic [1:0] STATUS_NO_CLOSE = 2'd2;

   typedef enum logic [3:0] {
      PH_SKIP   = 4'b0001,
      PH_SIGN   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic      seen_first;
      logic      open_bad;
      phase_type phase;
      logic      is_negative;
      logic      last_close;
      logic      just_opened;
   } ctrl_type;

   localparam ctrl_type CTRL_RESET = '{
      seen_first:  1'b0,
      open_bad:    1'b0,
      phase:       PH_SKIP,
      is_negative: 1'b0,
      last_close:  1'b0,
      just_opened: 1'b0
   };

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0]   value;
      logic                         value_valid;
      logic                         list_done;
      logic [1:0]                   status;
      logic [COUNT_BITS-1:0]        element_count;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- design/bilp_step.sv -----
// ----------------------------------------------------------------------------
// bilp_step
// Per-character next-state and result logic of the list parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bilp_step
   import bilp_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  ctrl_type               ctrl,
   input  logic [VALUE_BITS-1:0]  acc,
   input  logic [COUNT_BITS-1:0]  count,
   input  req_payload_type        req,
   output ctrl_type               ctrl_next,
   output logic [VALUE_BITS-1:0]  acc_next,
   output logic [COUNT_BITS-1:0]  count_next,
   output logic                   has_result,
   output rsp_payload_type        rsp
);

   localparam logic [VALUE_BITS-1:0] CAP    = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] MAXPOS = CAP - 1'b1;
   localparam logic [VALUE_BITS-1:0] CAP_Q  = CAP / 10;
   localparam logic [3:0]            CAP_R  = 4'(CAP % 10);

   logic                   is_space;
   logic                   is_digit;
   logic                   is_ws;
   logic                   is_sep;
   logic [3:0]             digit;
   logic [VALUE_BITS-1:0]  limit;
   logic [VALUE_BITS+3:0]  times_ten;
   logic [VALUE_BITS-1:0]  acc_digit;
   logic                   emit;
   logic [VALUE_BITS-1:0]  pos_val;
   logic [VALUE_BITS+OUT_BITS-1:0] acc_wide;
   logic [VALUE_BITS+OUT_BITS-1:0] pos_wide;
   logic [OUT_BITS-1:0]    value_out;
   ctrl_type               upd;

   assign is_space = (req.char_code == CH_SPACE);
   assign is_digit = (req.char_code >= CH_ZERO) && (req.char_code <= CH_NINE);
   assign is_ws    = (req.char_code >= CH_TAB) && (req.char_code <= CH_CR);
   assign is_sep   = (req.char_code == CH_COMMA) || (req.char_code == CH_CLOSE);
   assign digit    = 4'(req.char_code - CH_ZERO);

   // (cap - d) / 10 is Q when d <= cap % 10, else Q - 1
   assign limit     = (digit > CAP_R) ? CAP_Q - 1'b1 : CAP_Q;
   assign times_ten = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VALUE_BITS+4)'(digit);
   assign acc_digit = (acc > limit) ? CAP : times_ten[VALUE_BITS-1:0];

   // finished element value from the current accumulator
   assign pos_val   = (acc > MAXPOS) ? MAXPOS : acc;
   assign acc_wide  = {{OUT_BITS{1'b0}}, acc};
   assign pos_wide  = {{OUT_BITS{1'b0}}, pos_val};
   assign value_out = ctrl.is_negative ? (OUT_BITS'(0) - acc_wide[OUT_BITS-1:0])
                                       : pos_wide[OUT_BITS-1:0];

   always_comb begin
      upd      = ctrl;
      acc_next = acc;
      emit     = 1'b0;
      if (!is_space) begin
         if (!ctrl.seen_first) begin
            upd.seen_first  = 1'b1;
            upd.open_bad    = (req.char_code != CH_OPEN);
            upd.just_opened = (req.char_code == CH_OPEN);
            upd.phase       = PH_SKIP;
            upd.is_negative = 1'b0;
            acc_next        = '0;
         end else if (is_sep) begin
            emit = !ctrl.open_bad && !((req.char_code == CH_CLOSE) && ctrl.just_opened);
            upd.phase       = PH_SKIP;
            upd.is_negative = 1'b0;
            upd.just_opened = 1'b0;
            acc_next        = '0;
         end else begin
            upd.just_opened = 1'b0;
            case (ctrl.phase)
               PH_SKIP: begin
                  if (is_ws) begin
                     upd.phase = PH_SKIP;
                  end else if ((req.char_code == CH_PLUS) || (req.char_code == CH_MINUS)) begin
                     upd.is_negative = (req.char_code == CH_MINUS);
                     upd.phase       = PH_SIGN;
                  end else if (is_digit) begin
                     acc_next  = acc_digit;
                     upd.phase = PH_DIGITS;
                  end else begin
                     upd.phase = PH_DONE;
                  end
               end
               PH_SIGN, PH_DIGITS: begin
                  if (is_digit) begin
                     acc_next  = acc_digit;
                     upd.phase = PH_DIGITS;
                  end else begin
                     upd.phase = PH_DONE;
                  end
               end
               default: begin
                  upd.phase = PH_DONE;
               end
            endcase
         end
         upd.last_close = (req.char_code == CH_CLOSE);
      end
   end

   always_comb begin
      logic [COUNT_BITS-1:0] cnt;
      cnt = (emit && (count != COUNT_MAX)) ? count + 1'b1 : count;

      rsp.value         = emit ? value_out : '0;
      rsp.value_valid   = emit;
      rsp.list_done     = req.end_of_text;
      rsp.element_count = cnt;
      if (!req.end_of_text) begin
         rsp.status = STATUS_OK;
      end else if (!upd.seen_first || upd.open_bad) begin
         rsp.status = STATUS_NO_OPEN;
      end else if (!upd.last_close) begin
         rsp.status = STATUS_NO_CLOSE;
      end else begin
         rsp.status = STATUS_OK;
      end
      has_result = emit || req.end_of_text;

      // the final character returns the control state and element count to reset
      if (req.end_of_text) begin
         ctrl_next  = CTRL_RESET;
         count_next = '0;
      end else begin
         ctrl_next  = upd;
         count_next = cnt;
      end
   end

endmodule

`default_nettype wire

// ----- design/bracketed_integer_list_parser.sv -----
// ----------------------------------------------------------------------------
// bracketed_integer_list_parser
// Streams "[a,b,c]" text one character per request into signed integers.
// ----------------------------------------------------------------------------
// Takes one character per clock and sustains one request per cycle while
// req_stall is low. Each request passes an input register, then the character
// decode, digit accumulate (shift-add times ten with saturation) and element
// emit logic, and lands in the result register, which drives rsp_valid. A
// request that neither closes an element nor ends the text produces no
// response. req_stall rises only when the input register holds a character
// that has a response of its own and the result register holds a response
// that is being stalled. Status arrives with the final character; values of
// a list whose status is not OK must be dropped by the consumer.
`timescale 1ns / 1ps
`default_nettype none

`include "bracketed_integer_list_parser_macros.svh"

module bracketed_integer_list_parser
   import bilp_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic                  in_valid_ff, in_valid_in;
   req_payload_type       in_data_ff, in_data_in;
   ctrl_type              ctrl_ff, ctrl_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   ctrl_type              step_ctrl;
   logic [VALUE_BITS-1:0] step_acc;
   logic [COUNT_BITS-1:0] step_count;
   logic                  step_has_result;
   rsp_payload_type       step_rsp;
   logic                  advance;
   logic                  fire;

   bilp_step #(
      .VALUE_BITS(VALUE_BITS)
   ) u_step (
      .ctrl       (ctrl_ff),
      .acc        (acc_ff),
      .count      (count_ff),
      .req        (in_data_ff),
      .ctrl_next  (step_ctrl),
      .acc_next   (step_acc),
      .count_next (step_count),
      .has_result (step_has_result),
      .rsp        (step_rsp)
   );

   // the held character moves on unless its response has nowhere to go
   assign advance   = !step_has_result || !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      ctrl_in      = ctrl_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_data_in  = req_payload;
      end
      if (fire) begin
         ctrl_in  = step_ctrl;
         acc_in   = step_acc;
         count_in = step_count;
         if (step_has_result) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = step_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         ctrl_ff      <= CTRL_RESET;
         acc_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         ctrl_ff      <= ctrl_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `BILP_NEVER(a_stall_needs_data, clock, reset,
      req_stall && !in_valid_ff,
      "req_stall with empty input register")
   `BILP_ASSERT(a_empty_value_zero, clock, reset,
      rsp_valid && !rsp_payload.value_valid |-> rsp_payload.value == '0,
      "response without element carries nonzero value")
   `BILP_ASSERT(a_status_on_done, clock, reset,
      rsp_valid && !rsp_payload.list_done |-> rsp_payload.status == STATUS_OK,
      "status reported before the final character")
   `BILP_ASSERT(a_reset_after_done, clock, reset,
      fire && in_data_ff.end_of_text |=> count_ff == '0 && !ctrl_ff.seen_first,
      "parser state not cleared after final character")

endmodule

`default_nettype wire
